// ----- hdl/jsu_pkg.sv -----
// shared types and constants for the json string unescape block
package jsu_pkg;

    localparam int POS_BITS  = 16;
    localparam int OUT_POS_W = 16;
    localparam int GRP_DEPTH = 4;
    localparam int GRP_PTR_W = $clog2(GRP_DEPTH);
    localparam int GRP_LVL_W = $clog2(GRP_DEPTH + 1);

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_CLOSE = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    typedef logic [3:0] t_err;
    localparam t_err ERR_NONE        = 4'd0;
    localparam t_err ERR_EXP_QUOTE   = 4'd1;
    localparam t_err ERR_CONTROL     = 4'd2;
    localparam t_err ERR_TRUNC_ESC   = 4'd3;
    localparam t_err ERR_BAD_ESC     = 4'd4;
    localparam t_err ERR_TRUNC_UNI   = 4'd5;
    localparam t_err ERR_BAD_HEX     = 4'd6;
    localparam t_err ERR_UNPAIR_HIGH = 4'd7;
    localparam t_err ERR_BAD_LOW     = 4'd8;
    localparam t_err ERR_UNPAIR_LOW  = 4'd9;
    localparam t_err ERR_UNTERM      = 4'd10;

    // all results caused by one input item; nm1 is the result count minus one
    typedef struct packed {
        logic [1:0]      nm1;
        t_kind           kind;
        logic [3:0][7:0] bytes;
        t_err            code;
        logic [OUT_POS_W-1:0] pos;
    } t_group;

endpackage

// ----- hdl/jsu_decode.sv -----
// input register, string state machine and utf-8 encoder
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_req_type,
    input  logic [7:0] i_in_byte,
    output logic       o_pending,
    output logic       o_push,
    output t_group     o_grp
);

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_STR    = 7'b0000010,
        M_ESC    = 7'b0000100,
        M_HEXHI  = 7'b0001000,
        M_WANTBS = 7'b0010000,
        M_WANTU  = 7'b0100000,
        M_HEXLO  = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [1:0]      nm1;
        logic [3:0][7:0] bytes;
    } t_utf8;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic                r_in_valid;
    logic                r_req;
    logic [7:0]          r_byte;
    t_mode               r_mode,   n_mode;
    logic [1:0]          r_hex_cnt, n_hex_cnt;
    logic [15:0]         r_high,   n_high;
    logic [15:0]         r_cur,    n_cur;
    logic [POS_BITS-1:0] r_pos,    n_pos;
    logic [POS_BITS-1:0] r_ustart, n_ustart;

    logic                pos_inc;
    logic [POS_BITS-1:0] pos_next;
    logic                hex_ok;
    logic [3:0]          hex_nib;
    logic [15:0]         new_unit;
    logic                err_hit;
    t_err                err_code;
    logic [POS_BITS-1:0] err_pos;
    logic                byte_hit;
    logic [7:0]          byte_val;
    logic                close_hit;
    logic                utf_hit;
    logic [20:0]         cp;
    t_utf8               enc;
    logic [POS_BITS+OUT_POS_W-1:0] pos_wide;

    function automatic t_utf8 utf8_enc(input logic [20:0] c);
        t_utf8 r;
        r.bytes = '0;
        if (c <= 21'h7f) begin
            r.nm1      = 2'd0;
            r.bytes[0] = c[7:0];
        end else if (c <= 21'h7ff) begin
            r.nm1      = 2'd1;
            r.bytes[0] = {3'b110, c[10:6]};
            r.bytes[1] = {2'b10, c[5:0]};
        end else if (c <= 21'hffff) begin
            r.nm1      = 2'd2;
            r.bytes[0] = {4'b1110, c[15:12]};
            r.bytes[1] = {2'b10, c[11:6]};
            r.bytes[2] = {2'b10, c[5:0]};
        end else begin
            r.nm1      = 2'd3;
            r.bytes[0] = {5'b11110, c[20:18]};
            r.bytes[1] = {2'b10, c[17:12]};
            r.bytes[2] = {2'b10, c[11:6]};
            r.bytes[3] = {2'b10, c[5:0]};
        end
        return r;
    endfunction

    always_comb begin
        hex_ok  = 1'b1;
        hex_nib = 4'd0;
        if (r_byte >= "0" && r_byte <= "9") begin
            hex_nib = 4'(r_byte - 8'h30);
        end else if (r_byte >= "a" && r_byte <= "f") begin
            hex_nib = 4'(r_byte - 8'h57);
        end else if (r_byte >= "A" && r_byte <= "F") begin
            hex_nib = 4'(r_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign new_unit = {r_cur[11:0], hex_nib};
    assign pos_next = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_high    = r_high;
        n_cur     = r_cur;
        n_pos     = r_pos;
        n_ustart  = r_ustart;
        pos_inc   = 1'b0;
        err_hit   = 1'b0;
        err_code  = ERR_NONE;
        err_pos   = '0;
        byte_hit  = 1'b0;
        byte_val  = r_byte;
        close_hit = 1'b0;
        utf_hit   = 1'b0;
        cp        = {5'd0, new_unit};

        if (r_in_valid) begin
            if (r_req) begin
                err_hit = 1'b1;
                case (r_mode)
                    M_STR: begin
                        err_code = ERR_UNTERM;
                        err_pos  = r_pos;
                    end
                    M_ESC: begin
                        err_code = ERR_TRUNC_ESC;
                        err_pos  = r_pos;
                    end
                    M_HEXHI, M_HEXLO: begin
                        err_code = ERR_TRUNC_UNI;
                        err_pos  = r_ustart;
                    end
                    M_WANTBS: begin
                        err_code = ERR_UNPAIR_HIGH;
                        err_pos  = r_pos;
                    end
                    M_WANTU: begin
                        err_code = ERR_UNPAIR_HIGH;
                        err_pos  = r_ustart;
                    end
                    default: begin
                        err_code = ERR_EXP_QUOTE;
                    end
                endcase
            end else begin
                pos_inc = (r_mode != M_IDLE);
                if (pos_inc) begin
                    n_pos = pos_next;
                end
                case (r_mode)
                    M_STR: begin
                        if (r_byte == "\"") begin
                            close_hit = 1'b1;
                            n_mode    = M_IDLE;
                        end else if (r_byte < 8'h20) begin
                            err_hit  = 1'b1;
                            err_code = ERR_CONTROL;
                            err_pos  = r_pos;
                        end else if (r_byte == "\\") begin
                            n_mode = M_ESC;
                        end else begin
                            byte_hit = 1'b1;
                        end
                    end
                    M_ESC: begin
                        n_mode   = M_STR;
                        byte_hit = 1'b1;
                        case (r_byte)
                            "\"", "\\", "/": byte_val = r_byte;
                            "b": byte_val = 8'h08;
                            "f": byte_val = 8'h0c;
                            "n": byte_val = 8'h0a;
                            "r": byte_val = 8'h0d;
                            "t": byte_val = 8'h09;
                            "u": begin
                                byte_hit  = 1'b0;
                                n_mode    = M_HEXHI;
                                n_hex_cnt = 2'd0;
                                n_cur     = '0;
                                n_ustart  = pos_next;
                            end
                            default: begin
                                byte_hit = 1'b0;
                                err_hit  = 1'b1;
                                err_code = ERR_BAD_ESC;
                                err_pos  = r_pos;
                            end
                        endcase
                    end
                    M_WANTBS: begin
                        if (r_byte != "\\") begin
                            err_hit  = 1'b1;
                            err_code = ERR_UNPAIR_HIGH;
                            err_pos  = r_pos;
                        end else begin
                            n_mode   = M_WANTU;
                            n_ustart = r_pos;
                        end
                    end
                    M_WANTU: begin
                        if (r_byte != "u") begin
                            err_hit  = 1'b1;
                            err_code = ERR_UNPAIR_HIGH;
                            err_pos  = r_ustart;
                        end else begin
                            n_mode    = M_HEXLO;
                            n_hex_cnt = 2'd0;
                            n_cur     = '0;
                            n_ustart  = pos_next;
                        end
                    end
                    M_HEXHI, M_HEXLO: begin
                        if (!hex_ok) begin
                            err_hit  = 1'b1;
                            err_code = ERR_BAD_HEX;
                            err_pos  = r_pos;
                        end else begin
                            n_cur = new_unit;
                            if (r_hex_cnt != 2'd3) begin
                                n_hex_cnt = r_hex_cnt + 2'd1;
                            end else begin
                                n_hex_cnt = 2'd0;
                                if (r_mode == M_HEXHI) begin
                                    if (new_unit >= 16'hd800 && new_unit <= 16'hdbff) begin
                                        n_high = new_unit;
                                        n_mode = M_WANTBS;
                                    end else if (new_unit >= 16'hdc00 &&
                                                 new_unit <= 16'hdfff) begin
                                        err_hit  = 1'b1;
                                        err_code = ERR_UNPAIR_LOW;
                                        err_pos  = r_ustart;
                                    end else begin
                                        n_mode  = M_STR;
                                        utf_hit = 1'b1;
                                    end
                                end else begin
                                    if (new_unit < 16'hdc00 || new_unit > 16'hdfff) begin
                                        err_hit  = 1'b1;
                                        err_code = ERR_BAD_LOW;
                                        err_pos  = r_ustart;
                                    end else begin
                                        n_mode  = M_STR;
                                        utf_hit = 1'b1;
                                        // join the surrogate pair into one code point
                                        cp = 21'h10000 + {1'b0, r_high[9:0], new_unit[9:0]};
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        if (r_byte == "\"") begin
                            n_mode    = M_STR;
                            n_pos     = POS_BITS'(1);
                            n_hex_cnt = 2'd0;
                            n_cur     = '0;
                            n_high    = '0;
                            n_ustart  = '0;
                        end else begin
                            err_hit  = 1'b1;
                            err_code = ERR_EXP_QUOTE;
                        end
                    end
                endcase
            end
            if (err_hit) begin
                n_mode = M_IDLE;
            end
        end
    end

    assign enc      = utf8_enc(cp);
    assign pos_wide = {{OUT_POS_W{1'b0}}, err_pos};

    always_comb begin
        o_grp.nm1   = 2'd0;
        o_grp.kind  = KIND_BYTE;
        o_grp.bytes = '0;
        o_grp.code  = ERR_NONE;
        o_grp.pos   = '0;
        if (err_hit) begin
            o_grp.kind = KIND_ERROR;
            o_grp.code = err_code;
            o_grp.pos  = pos_wide[OUT_POS_W-1:0];
        end else if (close_hit) begin
            o_grp.kind = KIND_CLOSE;
        end else if (utf_hit) begin
            o_grp.nm1   = enc.nm1;
            o_grp.bytes = enc.bytes;
        end else begin
            o_grp.bytes[0] = byte_val;
        end
    end

    assign o_push    = err_hit | close_hit | utf_hit | byte_hit;
    assign o_pending = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_hex_cnt  <= '0;
            r_high     <= '0;
            r_cur      <= '0;
            r_pos      <= '0;
            r_ustart   <= '0;
        end else begin
            r_in_valid <= i_take;
            r_mode     <= n_mode;
            r_hex_cnt  <= n_hex_cnt;
            r_high     <= n_high;
            r_cur      <= n_cur;
            r_pos      <= n_pos;
            r_ustart   <= n_ustart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_req  <= i_req_type;
            r_byte <= i_in_byte;
        end
    end

endmodule

// ----- hdl/jsu_out_queue.sv -----
// queue of result groups and serializer that sends one result per transfer
module jsu_out_queue
    import jsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_group               i_grp,
    output logic [GRP_LVL_W-1:0] o_level,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_out_kind,
    output logic [7:0]           o_out_byte,
    output logic [3:0]           o_error_code,
    output logic [15:0]          o_error_position,
    output logic                 o_last
);

    t_group               r_mem [GRP_DEPTH];
    logic [GRP_PTR_W-1:0] r_wptr,  n_wptr;
    logic [GRP_PTR_W-1:0] r_rptr,  n_rptr;
    logic [GRP_LVL_W-1:0] r_level, n_level;
    logic [1:0]           r_idx,   n_idx;
    t_group               head;
    logic                 xfer;
    logic                 pop;

    assign head    = r_mem[r_rptr];
    assign o_valid = (r_level != '0);
    assign o_last  = (r_idx == head.nm1);
    assign xfer    = o_valid & ~i_stall;
    assign pop     = xfer & o_last;

    assign o_out_kind       = head.kind;
    assign o_out_byte       = head.bytes[r_idx];
    assign o_error_code     = head.code;
    assign o_error_position = head.pos;
    assign o_level          = r_level;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        n_idx   = r_idx;
        if (i_push) begin
            n_wptr = (r_wptr == GRP_PTR_W'(GRP_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (xfer) begin
            n_idx = r_idx + 2'd1;
        end
        if (pop) begin
            n_idx  = 2'd0;
            n_rptr = (r_rptr == GRP_PTR_W'(GRP_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
            r_idx   <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

endmodule

// ----- hdl/json_string_unescape.sv -----
// top level: decodes one quoted json string into utf-8 bytes, close and error results
// an item is decoded in the cycle after its transfer; its first result is written into the
// result-group queue and shows at the output once the queue holds it
// one item is taken every cycle while the four-entry result-group queue has room
// results leave at one per cycle while i_stall is low; a \u escape gives up to four bytes
// synchronous active-low reset: waits for an opening quote, position zero, queue empty
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_error_code,
    output logic [15:0] o_error_position,
    output logic        o_last
);

    logic                 take;
    logic                 pending;
    logic                 push;
    t_group               grp;
    logic [GRP_LVL_W-1:0] level;

    // keep one slot free for the item already in the decode register
    assign o_stall = (level == GRP_LVL_W'(GRP_DEPTH)) ||
                     ((level == GRP_LVL_W'(GRP_DEPTH - 1)) && pending);
    assign take    = i_valid & ~o_stall;

    jsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_req_type (i_req_type),
        .i_in_byte  (i_in_byte),
        .o_pending  (pending),
        .o_push     (push),
        .o_grp      (grp)
    );

    jsu_out_queue u_out_queue (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_grp            (grp),
        .o_level          (level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_error_code     (o_error_code),
        .o_error_position (o_error_position),
        .o_last           (o_last)
    );

endmodule
